// ===== sv/mmt_pkg.sv =====
// mmt_pkg: shared types and constants of the multicast membership table
// command, status and notice codes, entry layout and result record
// no dependencies
`default_nettype none

package mmt_pkg;

  // field widths
  localparam int CMD_W    = 2;
  localparam int KEY_W    = 64;
  localparam int SS_W     = 8;
  localparam int JS_W     = 4;
  localparam int STAT_W   = 2;
  localparam int NTC_W    = 2;
  localparam int FCOUNT_W = 7;

  // command codes
  localparam logic [CMD_W-1:0] CMD_JOIN   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LEAVE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd3;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_MEMBER = 2'd1;
  localparam logic [STAT_W-1:0] STAT_TABLE_FULL = 2'd2;

  // notice codes
  localparam logic [NTC_W-1:0] NTC_NONE       = 2'd0;
  localparam logic [NTC_W-1:0] NTC_FIRST_FULL = 2'd1;
  localparam logic [NTC_W-1:0] NTC_LAST_FULL  = 2'd2;

  // join-state masks
  localparam logic [JS_W-1:0] JS_ALL  = 4'hF;
  localparam logic [JS_W-1:0] JS_NONE = 4'h0;

  // full count saturation limit
  localparam logic [FCOUNT_W-1:0] FCOUNT_MAX = 7'd127;

  // one table entry as stored in memory
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [SS_W-1:0]  ss_byte;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // one result item
  typedef struct packed {
    logic [STAT_W-1:0]   status;
    logic                found;
    logic [SS_W-1:0]     scope_state_out;
    logic [NTC_W-1:0]    notice;
    logic                reroute;
    logic                group_removed;
    logic [FCOUNT_W-1:0] full_count;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/mmt_if.sv =====
// mmt_if: valid/ready channel interfaces of the multicast membership table
// request, result and configuration channels
// depends on mmt_pkg
`default_nettype none

interface mmt_req_if import mmt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [KEY_W-1:0]  port_key;
  logic [SS_W-1:0]   req_scope_state;

  modport source (output valid, cmd, port_key, req_scope_state, input ready);
  modport sink   (input valid, cmd, port_key, req_scope_state, output ready);
endinterface

interface mmt_res_if import mmt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STAT_W-1:0]   status;
  logic                found;
  logic [SS_W-1:0]     scope_state_out;
  logic [NTC_W-1:0]    notice;
  logic                reroute;
  logic                group_removed;
  logic [FCOUNT_W-1:0] full_count;

  modport source (output valid, status, found, scope_state_out, notice, reroute,
                  group_removed, full_count, input ready);
  modport sink   (input valid, status, found, scope_state_out, notice, reroute,
                  group_removed, full_count, output ready);
endinterface

interface mmt_cfg_if ();
  logic valid;
  logic ready;
  logic keep_group;

  modport source (output valid, keep_group, input ready);
  modport sink   (input valid, keep_group, output ready);
endinterface

`default_nettype wire

// ===== sv/mmt_ram.sv =====
// mmt_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`default_nettype none

module mmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/multicast_membership_table_core.sv =====
// multicast_membership_table_core: member table of one multicast group
// depends on mmt_pkg, mmt_if (channel interfaces) and mmt_ram
//
// Usage:
//   in_ch   request items (cmd, port_key, req_scope_state), valid/ready
//   out_ch  one result item per request, valid/ready
//   cfg_ch  write of the keep-group bit, always ready; write only when idle
// One request walks the whole member table through a single compare unit,
// one entry per cycle from the table RAM, then updates the entry and the
// full member count once the output register is free. Requests are taken
// only in the idle state, so a new request is not accepted until the
// previous one has finished its update step.
// When the last full member leaves, a clearing pass over every entry
// follows the result, and no request is taken during it.
// After reset the same clearing pass runs before the first request is
// accepted. The result sits in an output register: a new request is
// taken while it waits, but the next result stays held until the
// receiver takes the current one.
`default_nettype none

module multicast_membership_table_core import mmt_pkg::*; #(
  parameter int MAX_MEMBERS = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  mmt_req_if.sink   in_ch,
  mmt_res_if.source out_ch,
  mmt_cfg_if.sink   cfg_ch
);

  localparam int AW   = $clog2(MAX_MEMBERS);
  localparam int CNTW = AW + 1;
  localparam int CW   = $clog2(MAX_MEMBERS + 1);
  localparam int FW   = CW + FCOUNT_W;
  localparam logic [CNTW-1:0] CNT_END  = CNTW'(MAX_MEMBERS);
  localparam logic [CNTW-1:0] CNT_LAST = CNTW'(MAX_MEMBERS - 1);

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_SCAN, ST_EXEC} state_t;

  state_t            state_r;
  logic [CNTW-1:0]   cnt_r;
  logic              rd_vld_r;
  logic [AW-1:0]     rd_idx_r;
  logic [CMD_W-1:0]  cmd_r;
  logic [KEY_W-1:0]  key_r;
  logic [SS_W-1:0]   req_r;
  logic              hit_r;
  logic [AW-1:0]     hit_idx_r;
  logic [SS_W-1:0]   hit_ss_r;
  logic              free_r;
  logic [AW-1:0]     free_idx_r;
  logic [CW-1:0]     full_r;
  logic              keep_group_r;
  logic              out_valid_r;
  result_t           out_r;

  logic [ENTRY_W-1:0] rd_data;
  entry_t             rd_entry;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;

  logic               ex_we;
  logic [AW-1:0]      ex_addr;
  entry_t             ex_entry;
  result_t            res;
  logic [CW-1:0]      full_nxt;
  logic               clear_all;
  logic               exec_go;
  logic [JS_W-1:0]    leave_bits;
  logic [JS_W-1:0]    new_js;
  logic [JS_W-1:0]    join_js;
  logic [FW-1:0]      full_wide;

  // table memory
  mmt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_MEMBERS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(cnt_r[AW-1:0]),
    .rdata(rd_data)
  );

  assign rd_entry = entry_t'(rd_data);

  // handshakes
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign exec_go      = (state_r == ST_EXEC) && (!out_valid_r || out_ch.ready);

  // result channel
  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = out_r.status;
  assign out_ch.found           = out_r.found;
  assign out_ch.scope_state_out = out_r.scope_state_out;
  assign out_ch.notice          = out_r.notice;
  assign out_ch.reroute         = out_r.reroute;
  assign out_ch.group_removed   = out_r.group_removed;
  assign out_ch.full_count      = out_r.full_count;

  // update step: entry write-back, count and result from the scan outcome
  always_comb begin
    ex_we     = 1'b0;
    ex_addr   = hit_idx_r;
    ex_entry  = '{valid: 1'b1, key: key_r, ss_byte: hit_ss_r};
    res       = '0;
    full_nxt  = full_r;
    clear_all = 1'b0;
    join_js   = hit_ss_r[JS_W-1:0] | req_r[JS_W-1:0];
    leave_bits = (cmd_r == CMD_DELETE) ? JS_ALL : req_r[JS_W-1:0];
    new_js    = hit_ss_r[JS_W-1:0] & ~leave_bits;
    res.status = STAT_OK;
    res.notice = NTC_NONE;
    case (cmd_r)
      CMD_JOIN: begin
        if (hit_r) begin
          // existing member keeps its scope, join bits are merged
          ex_we = 1'b1;
          ex_entry.ss_byte = {hit_ss_r[SS_W-1:JS_W], join_js};
          res.found = 1'b1;
          res.scope_state_out = {hit_ss_r[SS_W-1:JS_W], join_js};
          if (req_r[0] && !hit_ss_r[0]) begin
            full_nxt = full_r + CW'(1);
            if (full_r == '0) begin
              res.notice = NTC_FIRST_FULL;
            end
          end
        end else if (free_r) begin
          // new member goes into the lowest free slot
          ex_we = 1'b1;
          ex_addr = free_idx_r;
          ex_entry.ss_byte = req_r;
          res.scope_state_out = req_r;
          res.reroute = 1'b1;
          if (req_r[0]) begin
            full_nxt = full_r + CW'(1);
            if (full_r == '0) begin
              res.notice = NTC_FIRST_FULL;
            end
          end
        end else begin
          res.status = STAT_TABLE_FULL;
        end
      end
      CMD_LEAVE, CMD_DELETE: begin
        if (!hit_r) begin
          res.status = STAT_NOT_MEMBER;
        end else begin
          res.found = 1'b1;
          ex_we = 1'b1;
          if (new_js != JS_NONE) begin
            ex_entry.ss_byte = {hit_ss_r[SS_W-1:JS_W], new_js};
            res.scope_state_out = {hit_ss_r[SS_W-1:JS_W], new_js};
          end else begin
            // no join bits left: entry removed
            ex_entry.valid = 1'b0;
            res.scope_state_out = hit_ss_r;
            res.reroute = 1'b1;
          end
          if (hit_ss_r[0] && !new_js[0] && (full_r != '0)) begin
            full_nxt = full_r - CW'(1);
            if (full_r == CW'(1)) begin
              // last full member gone: table cleared
              res.notice = NTC_LAST_FULL;
              clear_all = 1'b1;
              res.group_removed = !keep_group_r;
            end
          end
        end
      end
      CMD_QUERY: begin
        if (hit_r) begin
          res.found = 1'b1;
          res.scope_state_out = hit_ss_r;
        end else begin
          res.status = STAT_NOT_MEMBER;
        end
      end
      default: begin
        res.status = STAT_OK;
      end
    endcase
    // saturate the reported count
    full_wide = {{FCOUNT_W{1'b0}}, full_nxt};
    if (full_wide > FW'(FCOUNT_MAX)) begin
      res.full_count = FCOUNT_MAX;
    end else begin
      res.full_count = full_wide[FCOUNT_W-1:0];
    end
  end

  // memory write port: clearing pass or update step
  always_comb begin
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = cnt_r[AW-1:0];
      ram_wdata = '0;
    end else begin
      ram_we    = exec_go && ex_we;
      ram_waddr = ex_addr;
      ram_wdata = ex_entry;
    end
  end

  // sequencer, scan unit and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      cnt_r        <= '0;
      rd_vld_r     <= 1'b0;
      hit_r        <= 1'b0;
      free_r       <= 1'b0;
      full_r       <= '0;
      keep_group_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      // configuration write
      if (cfg_ch.valid) begin
        keep_group_r <= cfg_ch.keep_group;
      end
      // result taken
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          cnt_r <= cnt_r + CNTW'(1);
          if (cnt_r == CNT_LAST) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_ch.valid) begin
            cmd_r    <= in_ch.cmd;
            key_r    <= in_ch.port_key;
            req_r    <= in_ch.req_scope_state;
            hit_r    <= 1'b0;
            free_r   <= 1'b0;
            cnt_r    <= '0;
            rd_vld_r <= 1'b0;
            state_r  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // issue next read
          if (cnt_r != CNT_END) begin
            cnt_r <= cnt_r + CNTW'(1);
          end
          rd_vld_r <= (cnt_r != CNT_END);
          rd_idx_r <= cnt_r[AW-1:0];
          // compare the entry that came back
          if (rd_vld_r) begin
            if (rd_entry.valid && (rd_entry.key == key_r) && !hit_r) begin
              hit_r     <= 1'b1;
              hit_idx_r <= rd_idx_r;
              hit_ss_r  <= rd_entry.ss_byte;
            end
            if (!rd_entry.valid && !free_r) begin
              free_r     <= 1'b1;
              free_idx_r <= rd_idx_r;
            end
          end
          if ((cnt_r == CNT_END) && rd_vld_r) begin
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (exec_go) begin
            out_r       <= res;
            out_valid_r <= 1'b1;
            full_r      <= full_nxt;
            cnt_r       <= '0;
            state_r     <= clear_all ? ST_CLEAR : ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // reset always starts the clearing pass from entry zero
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (state_r == ST_CLEAR) && (cnt_r == '0))
    else $error("reset did not start the clearing pass");

  // losing the last full member clears the table after the result
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_go && clear_all) |=> (state_r == ST_CLEAR) && out_valid_r)
    else $error("table clear did not follow last full member leave");

  // last-member notice reports an empty group
  a_last_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.notice == NTC_LAST_FULL)) |-> (out_r.full_count == '0))
    else $error("last member notice with nonzero full count");

  // failed requests change nothing visible
  a_fail_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.status != STAT_OK)) |->
      (!out_r.reroute && !out_r.found && (out_r.notice == NTC_NONE)))
    else $error("failed request reported a change");

  // a new result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> $stable(out_r))
    else $error("result overwritten before it was taken");

endmodule

`default_nettype wire

// ===== dv/multicast_membership_table_checker.sv =====
// mmt_membership_checker: watches the request, result and config channels,
// predicts every result from its own copy of the member table and compares
// depends on mmt_pkg and mmt_if
`timescale 1ns / 1ps

module mmt_membership_checker import mmt_pkg::*; #(
  parameter int MAX_MEMBERS = 64
) (
  input  logic clk,
  input  logic rst_n,
  mmt_req_if   in_ch,
  mmt_res_if   out_ch,
  mmt_cfg_if   cfg_ch,
  output int   fail_count,
  output int   pending
);

  // shadow of the member table and group state
  logic             member_valid [MAX_MEMBERS];
  logic [KEY_W-1:0] member_key   [MAX_MEMBERS];
  logic [SS_W-1:0]  member_ss    [MAX_MEMBERS];
  int               full_cnt;
  logic             keep_group_q;

  result_t results_due [$];
  int      mismatch_total;
  int      result_index;

  // one request against the shadow table, returns the result it causes
  function automatic result_t apply_request(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                            logic [SS_W-1:0] req);
    result_t         r;
    int              slot;
    int              free_idx;
    logic [SS_W-1:0] stored;
    logic [JS_W-1:0] prev_js;
    logic [JS_W-1:0] clr;
    logic [JS_W-1:0] new_js;
    r = '0;
    slot = -1;
    free_idx = -1;
    for (int i = 0; i < MAX_MEMBERS; i++) begin
      if (slot < 0 && member_valid[i] && member_key[i] == key) slot = i;
      if (free_idx < 0 && !member_valid[i]) free_idx = i;
    end
    case (cmd)
      CMD_JOIN: begin
        if (slot >= 0) begin
          // existing member keeps its scope, join bits are merged
          stored = member_ss[slot];
          prev_js = stored[JS_W-1:0];
          r.found = 1'b1;
          member_ss[slot] = {stored[SS_W-1:JS_W], prev_js | req[JS_W-1:0]};
          r.scope_state_out = member_ss[slot];
          if (req[0] && !prev_js[0]) begin
            full_cnt++;
            if (full_cnt == 1) r.notice = NTC_FIRST_FULL;
          end
        end else if (free_idx < 0) begin
          r.status = STAT_TABLE_FULL;
        end else begin
          // new member goes into the lowest free slot
          member_valid[free_idx] = 1'b1;
          member_key[free_idx] = key;
          member_ss[free_idx] = req;
          r.scope_state_out = req;
          r.reroute = 1'b1;
          if (req[0]) begin
            full_cnt++;
            if (full_cnt == 1) r.notice = NTC_FIRST_FULL;
          end
        end
      end
      CMD_LEAVE, CMD_DELETE: begin
        if (slot < 0) begin
          r.status = STAT_NOT_MEMBER;
        end else begin
          stored = member_ss[slot];
          prev_js = stored[JS_W-1:0];
          clr = (cmd == CMD_DELETE) ? JS_ALL : req[JS_W-1:0];
          new_js = prev_js & ~clr;
          r.found = 1'b1;
          if (new_js != JS_NONE) begin
            member_ss[slot] = {stored[SS_W-1:JS_W], new_js};
            r.scope_state_out = member_ss[slot];
          end else begin
            // no join bits left, entry goes away
            r.scope_state_out = stored;
            member_valid[slot] = 1'b0;
            r.reroute = 1'b1;
          end
          if (prev_js[0] && !new_js[0] && full_cnt > 0) begin
            full_cnt--;
            if (full_cnt == 0) begin
              // last full member gone: whole table is dropped
              r.notice = NTC_LAST_FULL;
              for (int i = 0; i < MAX_MEMBERS; i++) member_valid[i] = 1'b0;
              if (!keep_group_q) r.group_removed = 1'b1;
            end
          end
        end
      end
      default: begin
        if (slot < 0) begin
          r.status = STAT_NOT_MEMBER;
        end else begin
          r.found = 1'b1;
          r.scope_state_out = member_ss[slot];
        end
      end
    endcase
    r.full_count = (full_cnt > 127) ? FCOUNT_MAX : FCOUNT_W'(full_cnt);
    return r;
  endfunction

  // channel monitor: compare results, then predict newly accepted items
  always @(posedge clk) begin
    result_t exp_r;
    result_t act_r;
    if (!rst_n) begin
      for (int i = 0; i < MAX_MEMBERS; i++) begin
        member_valid[i] = 1'b0;
        member_key[i] = '0;
        member_ss[i] = '0;
      end
      full_cnt = 0;
      keep_group_q = 1'b0;
      results_due.delete();
      mismatch_total = 0;
      result_index = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        act_r.status = out_ch.status;
        act_r.found = out_ch.found;
        act_r.scope_state_out = out_ch.scope_state_out;
        act_r.notice = out_ch.notice;
        act_r.reroute = out_ch.reroute;
        act_r.group_removed = out_ch.group_removed;
        act_r.full_count = out_ch.full_count;
        if (results_due.size() == 0) begin
          mismatch_total++;
          if (mismatch_total <= 10)
            $display("result %0d arrived with no request outstanding", result_index);
        end else begin
          exp_r = results_due.pop_front();
          if (act_r.status !== exp_r.status || act_r.found !== exp_r.found ||
              act_r.scope_state_out !== exp_r.scope_state_out ||
              act_r.notice !== exp_r.notice || act_r.reroute !== exp_r.reroute ||
              act_r.group_removed !== exp_r.group_removed ||
              act_r.full_count !== exp_r.full_count) begin
            mismatch_total++;
            if (mismatch_total <= 10) begin
              $display("result %0d mismatch: expected st=%0d fnd=%0d ss=%02h ntc=%0d %s",
                       result_index, exp_r.status, exp_r.found, exp_r.scope_state_out,
                       exp_r.notice, "");
              $display("  expected rr=%0d rm=%0d cnt=%0d",
                       exp_r.reroute, exp_r.group_removed, exp_r.full_count);
              $display("  got st=%0d fnd=%0d ss=%02h ntc=%0d rr=%0d rm=%0d cnt=%0d",
                       act_r.status, act_r.found, act_r.scope_state_out, act_r.notice,
                       act_r.reroute, act_r.group_removed, act_r.full_count);
            end
          end
        end
        result_index++;
      end
      if (in_ch.valid && in_ch.ready)
        results_due.push_back(apply_request(in_ch.cmd, in_ch.port_key,
                                            in_ch.req_scope_state));
      if (cfg_ch.valid && cfg_ch.ready) keep_group_q = cfg_ch.keep_group;
    end
    fail_count <= mismatch_total;
    pending <= results_due.size();
  end

endmodule

// ===== dv/tb_multicast_membership_table_core.sv =====
// tb_multicast_membership_table_core: drives join/leave/delete/query items and
// keep-group writes into the member table core, random idling on both sides
// depends on mmt_pkg, mmt_if, the core and mmt_membership_checker
`timescale 1ns / 1ps

module tb_multicast_membership_table_core;
  import mmt_pkg::*;

  localparam int MAX_MEMBERS = 64;
  localparam int TARGET_ITEMS = 1900;
  localparam int POOL_MAX = 80;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   pending;
  logic steady;
  int   items_sent;
  int   pool_size;
  logic [KEY_W-1:0] guid_pool [POOL_MAX];

  mmt_req_if in_ch ();
  mmt_res_if out_ch ();
  mmt_cfg_if cfg_ch ();

  multicast_membership_table_core #(.MAX_MEMBERS(MAX_MEMBERS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  mmt_membership_checker #(.MAX_MEMBERS(MAX_MEMBERS)) membership_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= steady || ($urandom_range(0, 99) >= 31);
    end
  end

  // one request item, sometimes with a random gap in front of it
  task automatic send_request(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] guid,
                              logic [SS_W-1:0] ss);
    int gap;
    if (!steady && $urandom_range(0, 99) < 31) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 80) : $urandom_range(1, 3);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.port_key <= guid;
    in_ch.req_scope_state <= ss;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // drain all results, then let a clearing pass finish
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (MAX_MEMBERS + 8) @(posedge clk);
  endtask

  task automatic write_keep_group(logic value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.keep_group <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // fresh random port identifiers, sometimes including the extreme keys
  task automatic refill_pool(int count);
    pool_size = count;
    for (int k = 0; k < count; k++) guid_pool[k] = {$urandom, $urandom};
    if ($urandom_range(0, 3) == 0) guid_pool[0] = '0;
    if (count > 1 && $urandom_range(0, 3) == 0) guid_pool[1] = '1;
  endtask

  // mostly operations on pooled members, some noise with unknown ports
  task automatic random_request();
    int pick;
    logic [KEY_W-1:0] guid;
    logic [SS_W-1:0] ss;
    pick = $urandom_range(0, 99);
    guid = guid_pool[$urandom_range(0, pool_size - 1)];
    ss = SS_W'($urandom_range(0, 255));
    if (pick < 40) send_request(CMD_JOIN, guid, ss);
    else if (pick < 62) send_request(CMD_LEAVE, guid, ss);
    else if (pick < 72) send_request(CMD_DELETE, guid, ss);
    else if (pick < 90) send_request(CMD_QUERY, guid, ss);
    else send_request(CMD_W'($urandom_range(0, 3)), {$urandom, $urandom}, ss);
  endtask

  // stimulus and verdict
  initial begin
    int phase;
    int n;
    logic [KEY_W-1:0] key_lo;
    logic [KEY_W-1:0] key_hi;
    logic [KEY_W-1:0] key_mid;
    logic [KEY_W-1:0] key_alt;
    rst_n <= 1'b0;
    steady = 1'b0;
    items_sent = 0;
    in_ch.valid <= 1'b0;
    in_ch.cmd <= CMD_JOIN;
    in_ch.port_key <= '0;
    in_ch.req_scope_state <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.keep_group <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (MAX_MEMBERS + 8) @(posedge clk);
    write_keep_group(1'b0);

    // directed: absent ports, merge, empty join bits, last full member
    key_lo = '0;
    key_hi = '1;
    key_mid = 64'h5a5a_0f0f_c3c3_9696;
    key_alt = 64'h8000_0000_0000_0001;
    send_request(CMD_QUERY, key_lo, 8'h00);
    send_request(CMD_LEAVE, key_lo, 8'hff);
    send_request(CMD_DELETE, key_lo, 8'h00);
    send_request(CMD_JOIN, key_hi, 8'ha2);
    send_request(CMD_JOIN, key_hi, 8'h51);
    send_request(CMD_QUERY, key_hi, 8'h00);
    send_request(CMD_JOIN, key_lo, 8'h00);
    send_request(CMD_LEAVE, key_lo, 8'h00);
    send_request(CMD_JOIN, key_mid, 8'hff);
    send_request(CMD_JOIN, key_mid, 8'h01);
    send_request(CMD_LEAVE, key_hi, 8'h02);
    send_request(CMD_LEAVE, key_hi, 8'hf1);
    send_request(CMD_DELETE, key_mid, 8'h00);
    send_request(CMD_QUERY, key_mid, 8'h00);
    wait_idle();

    // directed: a kept group only loses its table
    write_keep_group(1'b1);
    send_request(CMD_JOIN, key_alt, 8'h01);
    send_request(CMD_JOIN, key_lo, 8'h38);
    send_request(CMD_DELETE, key_alt, 8'hff);
    send_request(CMD_QUERY, key_lo, 8'h00);

    // random phases, each under its own keep-group setting
    phase = 0;
    while (items_sent < TARGET_ITEMS) begin
      wait_idle();
      write_keep_group(1'($urandom_range(0, 1)));
      steady = (phase == 2);
      if (phase % 4 == 3) begin
        // fill the table past its size, then churn on those members
        refill_pool(MAX_MEMBERS + 8);
        for (int k = 0; k < pool_size; k++)
          send_request(CMD_JOIN, guid_pool[k], SS_W'($urandom_range(0, 255)));
        n = 40;
      end else begin
        case ($urandom_range(0, 2))
          0:       refill_pool(2);
          1:       refill_pool(6);
          default: refill_pool(24);
        endcase
        n = $urandom_range(80, 200);
      end
      repeat (n) random_request();
      phase++;
    end
    steady = 1'b0;

    wait_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("tb_multicast_membership_table_core OK");
    end else begin
      $display("tb_multicast_membership_table_core NOT OK");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #30_000_000;
    $display("tb_multicast_membership_table_core NOT OK");
    $finish;
  end

endmodule
